/* sv/gbba_pkg.sv */
// Shared widths, codes and types of the grouped bitmap block allocator.
`timescale 1ns / 1ps

package gbba_pkg;

    localparam int BITMAP_BITS = 4096;
    localparam int WORD_W      = 32;
    localparam int WORDS       = BITMAP_BITS / WORD_W;
    localparam int WADDR_W     = $clog2(WORDS);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int BLK_W       = 12;
    localparam int CNT_W       = 13;
    localparam int MAX_GROUPS  = 16;
    localparam int GRP_W       = $clog2(MAX_GROUPS);
    localparam int STAT_W      = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX         = 13'h1FFF;
    localparam logic [CNT_W-1:0] BITMAP_BITS_CNT = 13'd4096;
    localparam logic [CNT_W-1:0] TOTAL_RESET     = 13'd4096;
    localparam logic [CNT_W-1:0] GSIZE_RESET     = 13'd256;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status STAT_OK     = 2'd0;
    localparam t_status STAT_NOFREE = 2'd1;
    localparam t_status STAT_RANGE  = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_GSIZE = 1'b1;

endpackage

/* sv/gbba_req_if.sv */
// Request channel: valid/ready handshake with request type and block number.
`timescale 1ns / 1ps

interface gbba_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [gbba_pkg::BLK_W-1:0] block_number;

    modport source (output valid, output req_type, output block_number, input ready);
    modport sink   (input valid, input req_type, input block_number, output ready);
endinterface

/* sv/gbba_rsp_if.sv */
// Response channel: valid/ready handshake with status, grant and free counters.
`timescale 1ns / 1ps

interface gbba_rsp_if;
    logic                       valid;
    logic                       ready;
    gbba_pkg::t_status          status;
    logic [gbba_pkg::BLK_W-1:0] granted_block;
    logic [gbba_pkg::CNT_W-1:0] free_total;
    logic [gbba_pkg::CNT_W-1:0] free_in_group;

    modport source (output valid, output status, output granted_block,
                    output free_total, output free_in_group, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input free_total, input free_in_group, output ready);
endinterface

/* sv/gbba_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/grouped_bitmap_block_allocator.sv */
// Top level: first-fit block allocator over a grouped usage bitmap.
//
//  channel   dir   handshake         payload
//  i_req     in    valid/ready       req_type, block_number
//  o_rsp     out   valid/ready       status, granted_block, free_total, free_in_group
//  APB       in    psel/penable      total_blocks (0x0), group_size (0x4)
//
// A free goes from acceptance through setup, a 4-step group divider, then a
// read-modify-write of the group counter RAM. An allocate scans the bitmap words
// after setup, one per cycle from the bitmap RAM, before the divider.
// After reset and after every register write a clearing pass over all 128 words
// zeroes the bitmap and reloads the counters; no item is taken meanwhile.
// A finished result waits in the output register; the next item is accepted then.
`timescale 1ns / 1ps

module grouped_bitmap_block_allocator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    gbba_req_if.sink                             i_req,
    gbba_rsp_if.source                           o_rsp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gbba_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [gbba_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [gbba_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_GRD   = 3'd5;
    localparam logic [2:0] S_GWR   = 3'd6;
    localparam logic [2:0] S_FAIL  = 3'd7;

    localparam int BASE_W = gbba_pkg::CNT_W + gbba_pkg::GRP_W;

    function automatic logic [gbba_pkg::BIT_W-1:0] first_set(
        input logic [gbba_pkg::WORD_W-1:0] v
    );
        logic [gbba_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int i = gbba_pkg::WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = i[gbba_pkg::BIT_W-1:0];
            end
        end
        return idx;
    endfunction

    // configuration and control
    logic [2:0]                      r_state;
    logic [gbba_pkg::CNT_W-1:0]      r_total;
    logic [gbba_pkg::CNT_W-1:0]      r_gsize;
    logic [gbba_pkg::WADDR_W-1:0]    r_sw_idx;
    logic [BASE_W-1:0]               r_base;
    logic [BASE_W-1:0]               r_gclim;
    logic [gbba_pkg::CNT_W-1:0]      r_limit;
    logic [gbba_pkg::CNT_W-1:0]      r_gfree;

    // item in flight
    logic                            r_type;
    logic [gbba_pkg::BLK_W-1:0]      r_blk;
    logic [gbba_pkg::WADDR_W-1:0]    r_waddr;
    logic [gbba_pkg::BLK_W-1:0]      r_rem;
    logic [gbba_pkg::GRP_W-1:0]      r_q;
    logic [1:0]                      r_step;
    gbba_pkg::t_status               r_fail_stat;

    // output register
    logic                            r_out_valid;
    gbba_pkg::t_status               r_out_status;
    logic [gbba_pkg::BLK_W-1:0]      r_out_granted;
    logic [gbba_pkg::CNT_W-1:0]      r_out_total;
    logic [gbba_pkg::CNT_W-1:0]      r_out_group;

    // RAM ports
    logic                            bm_we;
    logic [gbba_pkg::WADDR_W-1:0]    bm_waddr;
    logic [gbba_pkg::WORD_W-1:0]     bm_wdata;
    logic                            bm_re;
    logic [gbba_pkg::WADDR_W-1:0]    bm_raddr;
    logic [gbba_pkg::WORD_W-1:0]     bm_rdata;
    logic                            gc_we;
    logic [gbba_pkg::GRP_W-1:0]      gc_waddr;
    logic [gbba_pkg::CNT_W-1:0]      gc_wdata;
    logic                            gc_re;
    logic [gbba_pkg::CNT_W-1:0]      gc_rdata;

    logic [gbba_pkg::CNT_W-1:0]      eff_t;
    logic [gbba_pkg::CNT_W-1:0]      eff_gs;
    logic                            cfg_wr;
    logic                            in_acc;
    logic                            out_free;
    logic                            out_load;

    logic                            sw_grp;
    logic                            sw_in;
    logic [BASE_W-1:0]               sw_end;
    logic [gbba_pkg::CNT_W-1:0]      sw_left;
    logic [gbba_pkg::CNT_W-1:0]      sw_n;
    logic [gbba_pkg::CNT_W-1:0]      sw_lim;

    logic [gbba_pkg::CNT_W-1:0]      sc_rem;
    logic [gbba_pkg::WORD_W-1:0]     sc_mask;
    logic [gbba_pkg::WORD_W-1:0]     sc_clr;
    logic [gbba_pkg::BIT_W-1:0]      sc_bit;
    logic                            sc_found;
    logic                            sc_more;

    logic [BASE_W-1:0]               dv_sh;
    logic                            dv_ge;

    logic [gbba_pkg::CNT_W-1:0]      g_new;
    logic [gbba_pkg::CNT_W-1:0]      gf_new;

    assign eff_t  = (r_total > gbba_pkg::BITMAP_BITS_CNT) ? gbba_pkg::BITMAP_BITS_CNT : r_total;
    assign eff_gs = (r_gsize == '0) ? {{(gbba_pkg::CNT_W-1){1'b0}}, 1'b1} : r_gsize;

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == gbba_pkg::CFG_GSIZE)
                    ? {{(gbba_pkg::CFG_DATA_W-gbba_pkg::CNT_W){1'b0}}, r_gsize}
                    : {{(gbba_pkg::CFG_DATA_W-gbba_pkg::CNT_W){1'b0}}, r_total};

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign out_load    = out_free && !cfg_wr && ((r_state == S_GWR) || (r_state == S_FAIL));

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_block = r_out_granted;
    assign o_rsp.free_total    = r_out_total;
    assign o_rsp.free_in_group = r_out_group;

    // clearing pass: group counter reload from a running group base
    assign sw_grp  = (r_sw_idx[gbba_pkg::WADDR_W-1:gbba_pkg::GRP_W] == '0);
    assign sw_in   = (r_base < {{gbba_pkg::GRP_W{1'b0}}, eff_t});
    assign sw_end  = r_base + {{gbba_pkg::GRP_W{1'b0}}, eff_gs};
    assign sw_left = eff_t - r_base[gbba_pkg::CNT_W-1:0];
    assign sw_n    = !sw_in ? '0 : ((sw_left < eff_gs) ? sw_left : eff_gs);
    assign sw_lim  = (sw_end < {{gbba_pkg::GRP_W{1'b0}}, eff_t})
                   ? sw_end[gbba_pkg::CNT_W-1:0] : eff_t;

    // scan: clear bits of the current word that lie below the limit
    assign sc_rem   = r_limit - {1'b0, r_waddr, {gbba_pkg::BIT_W{1'b0}}};
    assign sc_mask  = (sc_rem >= gbba_pkg::CNT_W'(gbba_pkg::WORD_W)) ? '1
                    : ((gbba_pkg::WORD_W'(1) << sc_rem[gbba_pkg::BIT_W-1:0])
                       - gbba_pkg::WORD_W'(1));
    assign sc_clr   = ~bm_rdata & sc_mask;
    assign sc_found = |sc_clr;
    assign sc_bit   = first_set(sc_clr);
    assign sc_more  = (sc_rem > gbba_pkg::CNT_W'(gbba_pkg::WORD_W));

    // one restoring step of the group divider
    assign dv_sh = {{gbba_pkg::GRP_W{1'b0}}, eff_gs} << r_step;
    assign dv_ge = ({{(BASE_W-gbba_pkg::BLK_W){1'b0}}, r_rem} >= dv_sh);

    assign g_new  = (r_type == gbba_pkg::REQ_ALLOC)
                  ? ((gc_rdata == '0) ? '0 : gc_rdata - gbba_pkg::CNT_W'(1))
                  : ((gc_rdata == gbba_pkg::CNT_MAX) ? gc_rdata
                                                     : gc_rdata + gbba_pkg::CNT_W'(1));
    assign gf_new = (r_type == gbba_pkg::REQ_ALLOC)
                  ? ((r_gfree == '0) ? '0 : r_gfree - gbba_pkg::CNT_W'(1))
                  : ((r_gfree == gbba_pkg::CNT_MAX) ? r_gfree
                                                    : r_gfree + gbba_pkg::CNT_W'(1));

    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = r_waddr;
        bm_wdata = bm_rdata;
        bm_re    = 1'b0;
        bm_raddr = r_waddr;
        gc_we    = 1'b0;
        gc_waddr = r_q;
        gc_wdata = g_new;
        gc_re    = 1'b0;
        unique case (r_state)
            S_CLR: begin
                bm_we    = 1'b1;
                bm_waddr = r_sw_idx;
                bm_wdata = '0;
                gc_we    = sw_grp;
                gc_waddr = r_sw_idx[gbba_pkg::GRP_W-1:0];
                gc_wdata = sw_n;
            end
            S_START: begin
                bm_re    = 1'b1;
                bm_raddr = (r_type == gbba_pkg::REQ_ALLOC) ? '0
                         : r_blk[gbba_pkg::BLK_W-1:gbba_pkg::BIT_W];
            end
            S_SCAN: begin
                if (sc_found) begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata | (gbba_pkg::WORD_W'(1) << sc_bit);
                end else if (sc_more) begin
                    bm_re    = 1'b1;
                    bm_raddr = r_waddr + gbba_pkg::WADDR_W'(1);
                end
            end
            S_GRD: begin
                gc_re = 1'b1;
                if (r_type == gbba_pkg::REQ_FREE) begin
                    bm_we    = 1'b1;
                    bm_waddr = r_blk[gbba_pkg::BLK_W-1:gbba_pkg::BIT_W];
                    bm_wdata = bm_rdata
                             & ~(gbba_pkg::WORD_W'(1) << r_blk[gbba_pkg::BIT_W-1:0]);
                end
            end
            S_GWR: begin
                gc_we = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_total     <= gbba_pkg::TOTAL_RESET;
            r_gsize     <= gbba_pkg::GSIZE_RESET;
            r_sw_idx    <= '0;
            r_base      <= '0;
            r_gclim     <= '0;
            r_limit     <= '0;
            r_gfree     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            // any register write restarts the clearing pass with the new sizes
            if (cfg_wr) begin
                if (paddr[2] == gbba_pkg::CFG_GSIZE) begin
                    r_gsize <= pwdata[gbba_pkg::CNT_W-1:0];
                end else begin
                    r_total <= pwdata[gbba_pkg::CNT_W-1:0];
                end
                r_state  <= S_CLR;
                r_sw_idx <= '0;
                r_base   <= '0;
                r_gclim  <= '0;
                r_limit  <= '0;
            end else begin
                unique case (r_state)
                    S_CLR: begin
                        if (r_sw_idx == '0) begin
                            r_gfree <= eff_t;
                        end
                        if (sw_grp) begin
                            r_base <= sw_end;
                            if (sw_in) begin
                                r_gclim <= sw_end;
                                r_limit <= sw_lim;
                            end
                        end
                        r_sw_idx <= r_sw_idx + gbba_pkg::WADDR_W'(1);
                        if (r_sw_idx == gbba_pkg::WADDR_W'(gbba_pkg::WORDS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (in_acc) begin
                            r_type  <= i_req.req_type;
                            r_blk   <= i_req.block_number;
                            r_state <= S_START;
                        end
                    end
                    S_START: begin
                        r_waddr <= '0;
                        r_q     <= '0;
                        r_step  <= 2'd3;
                        r_rem   <= r_blk;
                        if (r_type == gbba_pkg::REQ_ALLOC) begin
                            if (r_limit == '0) begin
                                r_fail_stat <= gbba_pkg::STAT_NOFREE;
                                r_state     <= S_FAIL;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if ({{(BASE_W-gbba_pkg::BLK_W){1'b0}}, r_blk} >= r_gclim) begin
                            r_fail_stat <= gbba_pkg::STAT_RANGE;
                            r_state     <= S_FAIL;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                    S_SCAN: begin
                        if (sc_found) begin
                            r_blk   <= {r_waddr, sc_bit};
                            r_rem   <= {r_waddr, sc_bit};
                            r_state <= S_DIV;
                        end else if (sc_more) begin
                            r_waddr <= r_waddr + gbba_pkg::WADDR_W'(1);
                        end else begin
                            r_fail_stat <= gbba_pkg::STAT_NOFREE;
                            r_state     <= S_FAIL;
                        end
                    end
                    S_DIV: begin
                        if (dv_ge) begin
                            r_rem       <= r_rem - dv_sh[gbba_pkg::BLK_W-1:0];
                            r_q[r_step] <= 1'b1;
                        end
                        r_step <= r_step - 2'd1;
                        if (r_step == 2'd0) begin
                            r_state <= S_GRD;
                        end
                    end
                    S_GRD: begin
                        r_state <= S_GWR;
                    end
                    S_GWR: begin
                        if (out_free) begin
                            r_gfree       <= gf_new;
                            r_out_status  <= gbba_pkg::STAT_OK;
                            r_out_granted <= (r_type == gbba_pkg::REQ_ALLOC) ? r_blk : '0;
                            r_out_total   <= gf_new;
                            r_out_group   <= g_new;
                            r_state       <= S_IDLE;
                        end
                    end
                    S_FAIL: begin
                        if (out_free) begin
                            r_out_status  <= r_fail_stat;
                            r_out_granted <= '0;
                            r_out_total   <= r_gfree;
                            r_out_group   <= '0;
                            r_state       <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_CLR;
                    end
                endcase
            end
        end
    end

    gbba_ram #(
        .WIDTH (gbba_pkg::WORD_W),
        .DEPTH (gbba_pkg::WORDS)
    ) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    gbba_ram #(
        .WIDTH (gbba_pkg::CNT_W),
        .DEPTH (gbba_pkg::MAX_GROUPS)
    ) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (gc_we),
        .i_waddr (gc_waddr),
        .i_wdata (gc_wdata),
        .i_re    (gc_re),
        .i_raddr (r_q),
        .o_rdata (gc_rdata)
    );

endmodule
